@@ hdl/cell_voltage_frame_receiver_top_defines.svh @@
`ifndef CELL_VOLTAGE_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CELL_VOLTAGE_FRAME_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CVFR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cvfr assertion failed");

// next-cycle implication, checked while out of reset
`define CVFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cvfr assertion failed");

`endif

@@ hdl/cvfr_pkg.sv @@
`timescale 1ns / 1ps
package cvfr_pkg;

  localparam int NUM_CELLS  = 12;
  localparam int DATA_BYTES = (3 * NUM_CELLS + 1) / 2;

  localparam int BYTE_W       = 8;
  localparam int POS_W        = 5;
  localparam int CODE_W       = 12;
  localparam int CELL_INDEX_W = 4;
  localparam int VOLTAGE_W    = 15;
  localparam int CELL_W       = $clog2(NUM_CELLS);
  localparam int BASE_W       = $clog2(NUM_CELLS + 2);

  // crc is shifted a digit per cycle
  localparam int CRC_DIGIT_W = 2;
  localparam int CRC_DIGITS  = BYTE_W / CRC_DIGIT_W;
  localparam int CRC_CNT_W   = $clog2(CRC_DIGITS);

  localparam logic [BYTE_W-1:0] CRC_SEED_RST    = 8'h41;
  localparam logic [BYTE_W-1:0] CRC_POLY_RST    = 8'h07;
  localparam logic [CODE_W-1:0] CODE_OFFSET_RST = 12'd512;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_SEED    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_OFFSET = 2'd2;

  typedef struct packed {
    logic              start;
    logic              reload;
    logic [BYTE_W-1:0] init;
    logic [BYTE_W-1:0] data;
  } cvfr_crc_cmd_t;

endpackage

@@ hdl/cvfr_in_if.sv @@
`timescale 1ns / 1ps
interface cvfr_in_if import cvfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

@@ hdl/cvfr_out_if.sv @@
`timescale 1ns / 1ps
interface cvfr_out_if import cvfr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CELL_INDEX_W-1:0]     cell_index;
  logic signed [VOLTAGE_W-1:0] cell_voltage;
  logic                        pec_ok;
  logic                        last;

  modport source (output valid, output cell_index, output cell_voltage,
                  output pec_ok, output last, input ready);
  modport sink (input valid, input cell_index, input cell_voltage,
                input pec_ok, input last, output ready);
endinterface

@@ hdl/cvfr_crc_serial.sv @@
`timescale 1ns / 1ps
module cvfr_crc_serial import cvfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cvfr_crc_cmd_t     cmd,
  input  logic [BYTE_W-1:0] poly,
  output logic [BYTE_W-1:0] rem,
  output logic              busy
);

  logic [BYTE_W-1:0]    shreg;
  logic [CRC_CNT_W-1:0] cnt;
  logic [BYTE_W-1:0]    rem_next;

  // msb-first, one digit of the byte per cycle
  always_comb begin
    rem_next = rem;
    for (int i = 0; i < CRC_DIGIT_W; i++) begin
      if (rem_next[BYTE_W-1] ^ shreg[BYTE_W-1-i]) begin
        rem_next = {rem_next[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        rem_next = {rem_next[BYTE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      rem  <= CRC_SEED_RST;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      rem   <= cmd.init;
      shreg <= cmd.data;
    end else if (cmd.reload) begin
      rem <= cmd.init;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= shreg << CRC_DIGIT_W;
      cnt   <= cnt + 1'b1;
      if (cnt == CRC_CNT_W'(CRC_DIGITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/cell_voltage_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// Cell voltage frame receiver. Takes a monitor read-back frame one byte per request
// (data bytes, then the packet error code byte) and returns one result per cell,
// (code - code_offset) * 3 in 0.5 mV units, or a single failure result when the
// error code does not match. After a data byte is accepted, no new byte is taken
// until the CRC-8 unit has shifted it in, two bits per cycle. After the code byte
// the cells leave at one result per cycle while the sink takes them, through a
// one-deep output register; no new byte is taken until the last result of the
// frame is in that register. A frame_start byte restarts the frame and reloads
// the CRC from crc_seed. Registers are written through cfg_we/cfg_index/cfg_data;
// the user writes them only while the block is idle; it does not enforce this.
`include "cell_voltage_frame_receiver_top_defines.svh"
module cell_voltage_frame_receiver_top import cvfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  cvfr_in_if.sink                frame,
  cvfr_out_if.source             result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_FAIL
  } state_t;

  state_t state;

  logic [BYTE_W-1:0] crc_seed;
  logic [BYTE_W-1:0] crc_poly;
  logic [CODE_W-1:0] code_offset;

  logic [POS_W-1:0]  pos;
  logic [1:0]        sub;
  logic [BASE_W-1:0] base;
  logic [BYTE_W-1:0] held_byte;
  logic [CELL_W-1:0] emit_idx;

  logic [CODE_W-1:0] cell_codes [NUM_CELLS];

  cvfr_crc_cmd_t     crc_cmd;
  logic [BYTE_W-1:0] crc_rem;
  logic              crc_busy;

  logic              accept;
  logic [POS_W-1:0]  pos_eff;
  logic [1:0]        sub_eff;
  logic [BASE_W-1:0] base_eff;
  logic              is_code_byte;
  logic              out_free;
  logic              wr_en;
  logic [BASE_W:0]   wr_idx;
  logic [CODE_W-1:0] wr_code;

  logic [CODE_W-1:0]           rd_code;
  logic signed [CODE_W:0]      diff;
  logic signed [VOLTAGE_W-1:0] volt;

  assign frame.ready = (state == S_IDLE) && !crc_busy;
  assign accept      = frame.valid && frame.ready;
  assign out_free    = !result.valid || result.ready;

  assign pos_eff      = frame.frame_start ? '0 : pos;
  assign sub_eff      = frame.frame_start ? 2'd0 : sub;
  assign base_eff     = frame.frame_start ? '0 : base;
  assign is_code_byte = (pos_eff == POS_W'(DATA_BYTES));

  // a cell is complete on the second and third byte of each group
  always_comb begin
    wr_idx  = {1'b0, base_eff};
    wr_code = {frame.rx_byte[3:0], held_byte};
    if (sub_eff == 2'd2) begin
      wr_idx  = {1'b0, base_eff} + 1'b1;
      wr_code = {frame.rx_byte, held_byte[7:4]};
    end
    wr_en = accept && !is_code_byte && (sub_eff != 2'd0)
            && (wr_idx < (BASE_W + 1)'(NUM_CELLS));
  end

  always_comb begin
    crc_cmd.start  = accept && !is_code_byte;
    crc_cmd.reload = accept && is_code_byte;
    crc_cmd.init   = (frame.frame_start || is_code_byte) ? crc_seed : crc_rem;
    crc_cmd.data   = frame.rx_byte;
  end

  cvfr_crc_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .poly (crc_poly),
    .rem  (crc_rem),
    .busy (crc_busy)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_codes[wr_idx[CELL_W-1:0]] <= wr_code;
    end
  end

  assign rd_code = cell_codes[emit_idx];
  assign diff    = $signed({1'b0, rd_code}) - $signed({1'b0, code_offset});
  // times three as x + 2x
  assign volt    = $signed({{2{diff[CODE_W]}}, diff}) + $signed({diff[CODE_W], diff, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed    <= CRC_SEED_RST;
      crc_poly    <= CRC_POLY_RST;
      code_offset <= CODE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_SEED:    crc_seed    <= cfg_data[BYTE_W-1:0];
        REG_CRC_POLY:    crc_poly    <= cfg_data[BYTE_W-1:0];
        REG_CODE_OFFSET: code_offset <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      sub          <= 2'd0;
      base         <= '0;
      held_byte    <= '0;
      emit_idx     <= '0;
      result.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (result.valid && result.ready) begin
            result.valid <= 1'b0;
          end
          if (accept) begin
            if (is_code_byte) begin
              pos      <= '0;
              sub      <= 2'd0;
              base     <= '0;
              emit_idx <= '0;
              state    <= (frame.rx_byte == crc_rem) ? S_EMIT : S_FAIL;
            end else begin
              pos       <= pos_eff + 1'b1;
              held_byte <= frame.rx_byte;
              if (sub_eff == 2'd2) begin
                sub  <= 2'd0;
                base <= base_eff + BASE_W'(2);
              end else begin
                sub  <= sub_eff + 1'b1;
                base <= base_eff;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.valid        <= 1'b1;
            result.cell_index   <= CELL_INDEX_W'(emit_idx);
            result.cell_voltage <= volt;
            result.pec_ok       <= 1'b1;
            result.last         <= (emit_idx == CELL_W'(NUM_CELLS - 1));
            if (emit_idx == CELL_W'(NUM_CELLS - 1)) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        S_FAIL: begin
          if (out_free) begin
            result.valid        <= 1'b1;
            result.cell_index   <= '0;
            result.cell_voltage <= '0;
            result.pec_ok       <= 1'b0;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CVFR_ASSERT_NEXT(a_accept_holds_off, clk, rst, accept, !frame.ready)
  `CVFR_ASSERT_NEXT(a_code_byte_emits, clk, rst, accept && is_code_byte, state != S_IDLE)
  `CVFR_ASSERT_IMPL(a_crc_blocks_input, clk, rst, crc_busy, !frame.ready)

endmodule
